/* hw/rtl/entropy_health_test_assert.svh */
// ----------------------------------------------------------------------------
// entropy health test assertion macros
// shared concurrent assertion forms, clocked and gated by the active low reset
// ----------------------------------------------------------------------------
`ifndef ENTROPY_HEALTH_TEST_ASSERT_SVH
`define ENTROPY_HEALTH_TEST_ASSERT_SVH

// same cycle implication
`define EHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("entropy health test: same cycle check failed");

// next cycle implication
`define EHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("entropy health test: next cycle check failed");

`endif

/* hw/rtl/eht_pkg.sv */
// ----------------------------------------------------------------------------
// eht_pkg
// types and constants shared by the entropy health test block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eht_pkg;

    localparam int RUN_W     = 8;
    localparam int CNT_W     = 7;
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
    localparam logic [RUN_W-1:0] RUN_ONE = 8'd1;

    localparam logic [RUN_W-1:0] MAX_REP_RESET = 8'd8;
    localparam logic [CNT_W-1:0] CUTOFF_RESET  = 7'd8;
    localparam logic [CNT_W-1:0] WINDOW_RESET  = 7'd16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx_raw;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_REPETITIONS = 2'd0,
        CFG_ADAPTIVE_CUTOFF = 2'd1,
        CFG_WINDOW_SIZE     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RUN_W-1:0] max_repetitions;
        logic [CNT_W-1:0] adaptive_cutoff;
        logic [CNT_W-1:0] window_size;
    } t_cfg;

    typedef struct packed {
        logic               repetition_fail;
        logic               adaptive_fail;
        logic [TOTAL_W-1:0] failure_total;
    } t_result;

endpackage

/* hw/rtl/eht_if.sv */
// ----------------------------------------------------------------------------
// eht interfaces
// sample, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eht_in_if #(parameter int SAMPLE_WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface eht_out_if #(parameter int SAMPLE_WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_out;
    logic                    repetition_fail;
    logic                    adaptive_fail;
    logic [15:0]             failure_total;

    modport source (output valid, output sample_out, output repetition_fail,
                    output adaptive_fail, output failure_total, input ready);
    modport sink   (input valid, input sample_out, input repetition_fail,
                    input adaptive_fail, input failure_total, output ready);
endinterface

interface eht_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/eht_core.sv */
// ----------------------------------------------------------------------------
// eht_core
// repetition count and adaptive proportion test state with failure total
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "entropy_health_test_assert.svh"

module eht_core #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  eht_pkg::t_cfg           i_cfg,
    output eht_pkg::t_result        o_result
);
    import eht_pkg::*;

    logic [SAMPLE_WIDTH-1:0] r_last;
    logic [RUN_W-1:0]        r_run;
    logic [SAMPLE_WIDTH-1:0] r_ref;
    logic [CNT_W-1:0]        r_match;
    logic [CNT_W-1:0]        r_pos;
    logic [TOTAL_W-1:0]      r_total;

    logic [SAMPLE_WIDTH-1:0] n_last;
    logic [RUN_W-1:0]        n_run;
    logic [SAMPLE_WIDTH-1:0] n_ref;
    logic [CNT_W-1:0]        n_match;
    logic [CNT_W-1:0]        n_pos;
    logic [TOTAL_W-1:0]      n_total;

    logic             rep_fail;
    logic             ada_fail;
    logic [CNT_W-1:0] match_inc;
    logic [CNT_W-1:0] pos_base;
    logic [CNT_W-1:0] pos_inc;

    // repetition count test
    always_comb begin
        n_last = r_last;
        if (i_sample == r_last) begin
            n_run = (r_run == RUN_MAX) ? RUN_MAX : r_run + RUN_ONE;
        end else begin
            n_last = i_sample;
            n_run  = RUN_ONE;
        end
        rep_fail = (n_run >= i_cfg.max_repetitions);
    end

    // adaptive proportion test
    always_comb begin
        n_ref     = r_ref;
        n_match   = r_match;
        ada_fail  = 1'b0;
        match_inc = r_match + CNT_W'(1);
        pos_base  = r_pos;
        pos_inc   = '0;
        if (r_pos == '0) begin
            n_ref   = i_sample;
            n_match = CNT_W'(1);
            n_pos   = CNT_W'(1);
        end else begin
            if (i_sample == r_ref) begin
                n_match = match_inc;
                if (match_inc == i_cfg.adaptive_cutoff) begin
                    ada_fail = 1'b1;
                    pos_base = '0;
                end
            end
            pos_inc = pos_base + CNT_W'(1);
            n_pos   = (pos_inc == i_cfg.window_size) ? '0 : pos_inc;
        end
    end

    assign n_total = r_total + TOTAL_W'(rep_fail) + TOTAL_W'(ada_fail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_run   <= RUN_ONE;
            r_ref   <= '0;
            r_match <= '0;
            r_pos   <= '0;
            r_total <= '0;
        end else if (i_step) begin
            r_last  <= n_last;
            r_run   <= n_run;
            r_ref   <= n_ref;
            r_match <= n_match;
            r_pos   <= n_pos;
            r_total <= n_total;
        end
    end

    assign o_result.repetition_fail = rep_fail;
    assign o_result.adaptive_fail   = ada_fail;
    assign o_result.failure_total   = n_total;

    `EHT_ASSERT_NOW(a_run_nonzero, i_clk, i_rst_n, 1'b1, r_run != '0)
    `EHT_ASSERT_NOW(a_window_open_no_fail, i_clk, i_rst_n, i_step && r_pos == '0, !ada_fail)
    `EHT_ASSERT_NEXT(a_window_open_state, i_clk, i_rst_n, i_step && r_pos == '0,
        r_pos == CNT_W'(1) && r_match == CNT_W'(1))
    `EHT_ASSERT_NEXT(a_double_fail, i_clk, i_rst_n, i_step && rep_fail && ada_fail,
        r_total == TOTAL_W'($past(r_total) + TOTAL_W'(2)))

endmodule

/* hw/rtl/entropy_health_test.sv */
// pipeline: a sample transaction passes the input register, then the result register,
//   before its result transaction
// throughput: one sample per cycle unless the result channel stalls; the tests are compares
//   and small counter updates done in one pass between the input and result registers
// reset: synchronous active low; resets both test states, clears the failure total and the
//   pipeline valids, and loads the register defaults (8, 8, 16)
// ----------------------------------------------------------------------------
// entropy_health_test
// top level: sample channel, configuration registers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entropy_health_test #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eht_in_if.sink    i_in,
    eht_out_if.source o_out,
    eht_cfg_if.sink   i_cfg
);
    import eht_pkg::*;

    t_cfg                    r_cfg;
    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;
    t_result                 r_out_result;

    t_result result;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_repetitions <= MAX_REP_RESET;
            r_cfg.adaptive_cutoff <= CUTOFF_RESET;
            r_cfg.window_size     <= WINDOW_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MAX_REPETITIONS: r_cfg.max_repetitions <= i_cfg.data;
                CFG_ADAPTIVE_CUTOFF: r_cfg.adaptive_cutoff <= i_cfg.data[CNT_W-1:0];
                CFG_WINDOW_SIZE:     r_cfg.window_size     <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_in.sample;
        end
        if (advance) begin
            r_out_sample <= r_in_sample;
            r_out_result <= result;
        end
    end

    eht_core #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_in_sample),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.sample_out      = r_out_sample;
    assign o_out.repetition_fail = r_out_result.repetition_fail;
    assign o_out.adaptive_fail   = r_out_result.adaptive_fail;
    assign o_out.failure_total   = r_out_result.failure_total;

endmodule
